// ===== hw/rtl/direct_ellipse_point_generator_defines.svh =====
// assertion macros for the ellipse point generator
`ifndef DIRECT_ELLIPSE_POINT_GENERATOR_DEFINES_SVH
`define DIRECT_ELLIPSE_POINT_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property holds at every edge outside reset
`define DEPG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("depg assertion failed");
// antecedent in one cycle implies consequent in the next
`define DEPG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("depg assertion failed");
`else
`define DEPG_ASSERT(lbl, clk, rst, prop)
`define DEPG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/depg_pkg.sv =====
`default_nettype none
package depg_pkg;

  // region codes
  localparam logic [1:0] REG_DONE = 2'd0;
  localparam logic [1:0] REG_ONE  = 2'd1;
  localparam logic [1:0] REG_TWO  = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic sqr;
    logic mul;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic wb;
    logic cap;
    logic to_r2;
    logic finish;
    logic push;
    logic push_null;
  } cmd_t;

  typedef struct packed {
    logic [1:0] region;
    logic       t1;
    logic       t2;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/depg_datapath.sv =====
`default_nettype none
module depg_datapath #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  parameter int FRAC_BITS   = 8
) (
  input  wire                         clk,
  input  wire                         rst,
  input  depg_pkg::cmd_t              cmd,
  output depg_pkg::status_t           status,
  input  wire  [COORD_BITS-1:0]       center_x,
  input  wire  [COORD_BITS-1:0]       center_y,
  input  wire  [RADIUS_BITS-1:0]      radius_a,
  input  wire  [RADIUS_BITS-1:0]      radius_b,
  input  wire                         out_ready,
  output logic                        out_valid,
  output logic                        res_valid,
  output logic                        res_last,
  output logic [8*(COORD_BITS+2)-1:0] pts
);
  import depg_pkg::*;

  localparam int POS = RADIUS_BITS + FRAC_BITS;
  localparam int SQ  = 2 * RADIUS_BITS;
  localparam int QW  = 2 * POS;
  localparam int OB  = COORD_BITS + 2;
  localparam int SW  = ((OB > RADIUS_BITS + 1) ? OB : RADIUS_BITS + 1) + 1;
  localparam logic [POS-1:0] ONE  = POS'(1) << FRAC_BITS;
  localparam logic [POS:0]   HALF = (POS + 1)'(1) << (FRAC_BITS - 1);

  logic [COORD_BITS-1:0]  cx, cy;
  logic [RADIUS_BITS-1:0] rb;
  logic [SQ-1:0]          a2, b2, sq, rem;
  logic [POS-1:0]         pos_x, pos_y, root;
  logic [1:0]             region;
  logic [2*SQ-1:0]        numer;
  logic [QW-1:0]          dq;
  logic [POS+1:0]         sr;
  logic [SQ+POS-1:0]      bx, ay;
  logic [RADIUS_BITS:0]   pend_ox, pend_oy;

  logic                   r1;
  logic [RADIUS_BITS-1:0] coord;
  logic [SQ-1:0]          big, mulv, dvs, diff;
  logic [SQ:0]            rem2, rem_sub;
  logic                   dge;
  logic [POS+3:0]         sr2, trial, sr_sub;
  logic                   sge;
  logic [POS:0]           rx, ry;
  logic [SW-1:0]          xp, xm, yp, ym;

  assign r1    = (region == REG_ONE);
  assign coord = r1 ? pos_y[POS-1:FRAC_BITS] : pos_x[POS-1:FRAC_BITS];
  assign big   = r1 ? b2 : a2;
  assign mulv  = r1 ? a2 : b2;
  assign dvs   = r1 ? b2 : a2;
  assign diff  = (sq > big) ? '0 : big - sq;

  // restoring divide, one quotient bit a step
  assign rem2    = {rem, dq[QW-1]};
  assign dge     = (rem2 >= {1'b0, dvs});
  assign rem_sub = rem2 - {1'b0, dvs};

  // digit-by-digit root, two radicand bits a step
  assign sr2    = {sr, dq[QW-1:QW-2]};
  assign trial  = {2'b00, root, 2'b01};
  assign sge    = (sr2 >= trial);
  assign sr_sub = sr2 - trial;

  assign rx = {1'b0, pos_x} + HALF;
  assign ry = {1'b0, pos_y} + HALF;

  assign xp = SW'(cx) + SW'(pend_ox);
  assign xm = SW'(cx) - SW'(pend_ox);
  assign yp = SW'(cy) + SW'(pend_oy);
  assign ym = SW'(cy) - SW'(pend_oy);

  always_ff @(posedge clk) begin
    bx <= (SQ + POS)'(b2) * (SQ + POS)'(pos_x);
    ay <= (SQ + POS)'(a2) * (SQ + POS)'(pos_y);
    if (cmd.load) begin
      cx    <= center_x;
      cy    <= center_y;
      rb    <= radius_b;
      a2    <= SQ'(radius_a) * SQ'(radius_a);
      b2    <= SQ'(radius_b) * SQ'(radius_b);
      pos_x <= {radius_a, {FRAC_BITS{1'b0}}};
      pos_y <= '0;
    end
    if (cmd.step) begin
      if (r1) begin
        pos_y <= pos_y + ONE;
      end else begin
        pos_x <= pos_x + ONE;
      end
    end
    if (cmd.sqr) sq <= SQ'(coord) * SQ'(coord);
    if (cmd.mul) numer <= (2 * SQ)'(mulv) * (2 * SQ)'(diff);
    if (cmd.div_init) begin
      rem <= numer[2*SQ-1:SQ];
      dq  <= {numer[SQ-1:0], {(2 * FRAC_BITS){1'b0}}};
    end
    if (cmd.div_step) begin
      rem <= dge ? rem_sub[SQ-1:0] : rem2[SQ-1:0];
      dq  <= {dq[QW-2:0], dge};
    end
    if (cmd.sqrt_init) begin
      sr   <= '0;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      sr   <= sge ? sr_sub[POS+1:0] : sr2[POS+1:0];
      root <= {root[POS-2:0], sge};
      dq   <= {dq[QW-3:0], 2'b00};
    end
    if (cmd.wb) begin
      if (r1) begin
        pos_x <= (dvs == '0) ? '0 : root;
      end else begin
        pos_y <= (dvs == '0) ? '0 : root;
      end
    end
    if (cmd.cap) begin
      pend_ox <= rx[POS:FRAC_BITS];
      pend_oy <= ry[POS:FRAC_BITS];
    end
    if (cmd.to_r2) begin
      pos_x <= '0;
      pos_y <= {rb, {FRAC_BITS{1'b0}}};
    end
    if (cmd.push) begin
      res_valid <= 1'b1;
      res_last  <= (region == REG_DONE);
      pts       <= {yp[OB-1:0], xm[OB-1:0], ym[OB-1:0], xm[OB-1:0],
                    ym[OB-1:0], xp[OB-1:0], yp[OB-1:0], xp[OB-1:0]};
    end else if (cmd.push_null) begin
      res_valid <= 1'b0;
      res_last  <= 1'b0;
      pts       <= '0;
    end
  end

  // mirror points packed from low: xrl yrl xru yru xlu ylu xll yll

  always_ff @(posedge clk) begin
    if (rst) begin
      region    <= REG_DONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) region <= REG_ONE;
      else if (cmd.to_r2) region <= REG_TWO;
      else if (cmd.finish) region <= REG_DONE;
      if (cmd.push || cmd.push_null) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign status.region   = region;
  assign status.t1       = (bx > ay);
  assign status.t2       = (bx < ay);
  assign status.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/depg_controller.sv =====
`default_nettype none
`include "direct_ellipse_point_generator_defines.svh"
module depg_controller #(
  parameter int RADIUS_BITS = 11,
  parameter int FRAC_BITS   = 8
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                mode,
  output logic               in_ready,
  input  depg_pkg::status_t  status,
  output depg_pkg::cmd_t     cmd
);
  import depg_pkg::*;

  localparam int POS = RADIUS_BITS + FRAC_BITS;
  localparam int QW  = 2 * POS;
  localparam int CW  = $clog2(QW);
  localparam logic [CW-1:0] DIV_LAST  = CW'(QW - 1);
  localparam logic [CW-1:0] SQRT_LAST = CW'(POS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQR  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIVI = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_PROD = 4'd7;
  localparam logic [3:0] S_T1   = 4'd8;
  localparam logic [3:0] S_T2W  = 4'd9;
  localparam logic [3:0] S_T2   = 4'd10;
  localparam logic [3:0] S_PUSH = 4'd11;
  localparam logic [3:0] S_NULL = 4'd12;

  logic [3:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!mode) begin
            cmd.load   = 1'b1;
            state_next = S_PROD;
          end else if (status.region == REG_DONE) begin
            state_next = S_NULL;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_SQR;
          end
        end
      end
      S_SQR: begin
        cmd.sqr    = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          cmd.sqrt_init = 1'b1;
          cnt_next      = '0;
          state_next    = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == SQRT_LAST) state_next = S_WB;
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.cap    = 1'b1;
        state_next = S_T1;
      end
      S_T1: begin
        if (status.region == REG_ONE && !status.t1) begin
          cmd.to_r2  = 1'b1;
          state_next = S_T2W;
        end else begin
          state_next = S_T2;
        end
      end
      S_T2W: state_next = S_T2;
      S_T2: begin
        if (status.region == REG_TWO && !status.t2) cmd.finish = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_NULL: begin
        if (status.out_free) begin
          cmd.push_null = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `DEPG_ASSERT_NEXT(a_div_to_root, clk, rst, state == S_DIV && cnt == DIV_LAST, state == S_SQRT)
  `DEPG_ASSERT(a_one_action, clk, rst, $onehot0({cmd.load, cmd.step, cmd.wb, cmd.push, cmd.push_null}))
  `DEPG_ASSERT(a_push_room, clk, rst, !(cmd.push || cmd.push_null) || status.out_free)

endmodule
`default_nettype wire

// ===== hw/rtl/direct_ellipse_point_generator.sv =====
// channel | dir | tdata (low bit up)                         | tuser     | tlast
// s_      | in  | center_x, center_y, radius_a, radius_b      | mode      | -
// m_      | out | px/py right_low, right_up, left_up, left_low | valid_res | last
// start item: load, rounding, region tests, push, with a wait state (S_T2W)
//   when region two begins at once
// step item: advance, square, multiply, divide, root, write-back, then rounding,
//   region tests and push, with a wait state (S_T2W) on a region change
// one item in work at a time; s_tready is high only while idle
// an output register holds the result, so a stalled m_tready stalls only the next push
// rst is synchronous; after it a step item answers with an empty result
`default_nettype none
module direct_ellipse_point_generator #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11,
  parameter int FRAC_BITS   = 8
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  s_tvalid,
  output logic s_tready,
  // center_x, center_y, radius_a, radius_b, zero fill
  input  wire  [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_tdata,
  // mode: 0 start, 1 step
  input  wire  s_tuser,
  output logic m_tvalid,
  input  wire  m_tready,
  // px_right_low, py_right_low, px_right_up, py_right_up,
  // px_left_up, py_left_up, px_left_low, py_left_low
  output logic [((8*(COORD_BITS+2)+7)/8)*8-1:0] m_tdata,
  // valid_res
  output logic m_tuser,
  output logic m_tlast
);
  import depg_pkg::*;

  localparam int OB  = COORD_BITS + 2;
  localparam int MTW = ((8 * OB + 7) / 8) * 8;

  cmd_t               cmd;
  status_t            status;
  logic [8*OB-1:0]    pts;

  depg_controller #(
    .RADIUS_BITS(RADIUS_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .mode    (s_tuser),
    .in_ready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  depg_datapath #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .center_x (s_tdata[COORD_BITS-1:0]),
    .center_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .radius_a (s_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .radius_b (s_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS]),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .res_valid(m_tuser),
    .res_last (m_tlast),
    .pts      (pts)
  );

  assign m_tdata = MTW'(pts);

endmodule
`default_nettype wire
